// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned PRIO_BITS   = 2;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic exec;
  } spq_cmd_t;

endpackage

// ----- rtl/core/spq_if.sv -----
interface spq_req_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [PRIO_BITS-1:0] entry_priority;
  logic [TAG_BITS-1:0]  entry_tag;

  modport source (output valid, output req_type, output entry_priority, output entry_tag,
                  input ready);
  modport sink   (input valid, input req_type, input entry_priority, input entry_tag,
                  output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 head_valid;
  logic [PRIO_BITS-1:0] head_priority;
  logic [TAG_BITS-1:0]  head_tag;
  logic [CNT_W-1:0]     entry_count;

  modport source (output valid, output status, output head_valid, output head_priority,
                  output head_tag, output entry_count, input ready);
  modport sink   (input valid, input status, input head_valid, input head_priority,
                  input head_tag, input entry_count, output ready);
endinterface

// ----- rtl/core/stable_priority_queue.sv -----
// stable priority queue of tagged entries
// req channel: one beat is an insert (req_type 0, priority and tag) or a
//   remove of the head entry (req_type 1); a beat moves when valid and ready
// rsp channel: one beat per request with status (ok, remove on empty,
//   insert on full), the head entry and the entry count after the request
// higher priority is served first, equal priorities leave in arrival order;
//   a priority equal to the low level register always goes to the tail
// the response is registered and valid in the cycle after the request is taken
// throughput: one request per cycle; the whole entry row shifts in parallel
//   and the insert slot is found by one compare per entry in the same cycle
// the response register is released and refilled in the same cycle, so
//   requests keep flowing while the receiver takes every response
// when the receiver stalls, the response holds and req ready goes low
// cfg_we_i writes the low level register; write only while no request is open
// reset empties the queue and clears the low level to 0; no clearing pass
module stable_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spq_pkg::PRIO_BITS-1:0] cfg_wdata_i,
  spq_req_if.sink                       req,
  spq_rsp_if.source                     rsp
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req.req_type),
    .entry_priority_i (req.entry_priority),
    .entry_tag_i      (req.entry_tag),
    .status_o         (rsp.status),
    .head_valid_o     (rsp.head_valid),
    .head_priority_o  (rsp.head_priority),
    .head_tag_o       (rsp.head_tag),
    .entry_count_o    (rsp.entry_count)
  );

endmodule

// ----- rtl/core/spq_ctrl.sv -----
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a beat enters when idle, or whenever the held result leaves in the same cycle
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (accept) state_d = CTRL_HOLD;
      end
      CTRL_HOLD: begin
        if (accept)           state_d = CTRL_HOLD;
        else if (out_ready_i) state_d = CTRL_IDLE;
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
      end
      CTRL_HOLD: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.exec = in_valid_i && in_ready_o;
  end

endmodule

// ----- rtl/core/spq_datapath.sv -----
module spq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::spq_cmd_t             cmd_i,
  input  logic                          cfg_we_i,
  input  logic [spq_pkg::PRIO_BITS-1:0] cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [spq_pkg::PRIO_BITS-1:0] entry_priority_i,
  input  logic [spq_pkg::TAG_BITS-1:0]  entry_tag_i,
  output logic [1:0]                    status_o,
  output logic                          head_valid_o,
  output logic [spq_pkg::PRIO_BITS-1:0] head_priority_o,
  output logic [spq_pkg::TAG_BITS-1:0]  head_tag_o,
  output logic [spq_pkg::CNT_W-1:0]     entry_count_o
);
  import spq_pkg::*;

  logic [PRIO_BITS-1:0] prio_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  tag_q  [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prio_d [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  tag_d  [QUEUE_DEPTH];
  logic [CNT_W-1:0]     occ_q, occ_d;
  status_e              status_q, status_d;
  logic [PRIO_BITS-1:0] level_q;
  logic                 full, empty, do_ins, do_rem;
  logic [IDX_W-1:0]     pos;

  assign full   = (occ_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (occ_q == '0);
  assign do_ins = cmd_i.exec && (req_type_i == REQ_INSERT) && !full;
  assign do_rem = cmd_i.exec && (req_type_i == REQ_REMOVE) && !empty;

  // first held cell of strictly lower priority, else the tail (always for the low level)
  always_comb begin
    pos = occ_q[IDX_W-1:0];
    if (entry_priority_i != level_q) begin
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if ((CNT_W'(i) < occ_q) && (prio_q[i] < entry_priority_i)) pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_d[i] = prio_q[i];
      tag_d[i]  = tag_q[i];
      if (do_ins) begin
        if (IDX_W'(i) == pos) begin
          prio_d[i] = entry_priority_i;
          tag_d[i]  = entry_tag_i;
        end else if ((i > 0) && (IDX_W'(i) > pos)) begin
          prio_d[i] = prio_q[(i > 0) ? i - 1 : 0];
          tag_d[i]  = tag_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem && (i < QUEUE_DEPTH - 1)) begin
        prio_d[i] = prio_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        tag_d[i]  = tag_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = status_q;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      if (req_type_i == REQ_INSERT) begin
        if (full) status_d = ST_FULL;
        else      occ_d    = occ_q + CNT_W'(1);
      end else begin
        if (empty) status_d = ST_EMPTY;
        else       occ_d    = occ_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_q[i] <= prio_d[i];
      tag_q[i]  <= tag_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      status_q <= ST_OK;
      level_q  <= '0;
    end else begin
      occ_q    <= occ_d;
      status_q <= status_d;
      if (cfg_we_i) level_q <= cfg_wdata_i;
    end
  end

  assign status_o        = status_q;
  assign head_valid_o    = !empty;
  assign head_priority_o = empty ? '0 : prio_q[0];
  assign head_tag_o      = empty ? '0 : tag_q[0];
  assign entry_count_o   = occ_q;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import spq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    status_e              status;
    logic                 head_valid;
    logic [PRIO_BITS-1:0] head_priority;
    logic [TAG_BITS-1:0]  head_tag;
    logic [CNT_W-1:0]     entry_count;
  } head_report_t;

  class queue_shadow;
    logic [PRIO_BITS-1:0] slot_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  slot_tag  [QUEUE_DEPTH];
    int                   fill;
    logic [PRIO_BITS-1:0] low_level;
    head_report_t         head_reports[$];
    int unsigned          errors;

    function new();
      fill      = 0;
      low_level = '0;
      errors    = 0;
    endfunction

    function int outstanding();
      return head_reports.size();
    endfunction

    function void set_low_level(logic [PRIO_BITS-1:0] lvl);
      low_level = lvl;
    endfunction

    // accepted request beat: update the shadow queue and queue its head report
    function void take_request(logic kind, logic [PRIO_BITS-1:0] prio,
                               logic [TAG_BITS-1:0] tag);
      head_report_t r;
      int           pos;
      bit           found;
      r.status = ST_OK;
      if (kind == REQ_INSERT) begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos   = fill;
          found = 1'b0;
          if (prio != low_level) begin
            for (int i = 0; i < fill; i++) begin
              if (!found && slot_prio[i] < prio) begin
                pos   = i;
                found = 1'b1;
              end
            end
          end
          for (int i = fill; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = prio;
          slot_tag[pos]  = tag;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 1; i < fill; i++) begin
            slot_prio[i-1] = slot_prio[i];
            slot_tag[i-1]  = slot_tag[i];
          end
          fill--;
        end
      end
      r.head_valid    = (fill > 0);
      r.head_priority = (fill > 0) ? slot_prio[0] : '0;
      r.head_tag      = (fill > 0) ? slot_tag[0] : '0;
      r.entry_count   = CNT_W'(fill);
      head_reports.push_back(r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void match_report(head_report_t got);
      head_report_t want;
      if (head_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected response beat: expected none actual status %0h count %0h",
                 $time, got.status, got.entry_count);
        return;
      end
      want = head_reports.pop_front();
      check_field("status", want.status, got.status);
      check_field("head_valid", want.head_valid, got.head_valid);
      check_field("head_priority", want.head_priority, got.head_priority);
      check_field("head_tag", want.head_tag, got.head_tag);
      check_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [PRIO_BITS-1:0] cfg_wdata;
  int unsigned          burst_left;
  int unsigned          cycles;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  queue_shadow tracker = new();

  stable_priority_queue DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch.sink),
    .rsp         (rsp_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // response side: check every accepted beat, then pick the next ready value
  initial begin
    int unsigned  cyc;
    int unsigned  stall_left;
    int unsigned  mode;
    head_report_t got;
    rsp_ch.ready <= 1'b0;
    cyc        = 0;
    stall_left = 0;
    mode       = 0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        got.status        = status_e'(rsp_ch.status);
        got.head_valid    = rsp_ch.head_valid;
        got.head_priority = rsp_ch.head_priority;
        got.head_tag      = rsp_ch.head_tag;
        got.entry_count   = rsp_ch.entry_count;
        tracker.match_report(got);
      end
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= (cyc % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
          end
        end
      endcase
    end
  end

  task automatic send_item(logic kind, logic [PRIO_BITS-1:0] prio, logic [TAG_BITS-1:0] tag);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.entry_priority <= prio;
    req_ch.entry_tag      <= tag;
    do @(posedge clk); while (!req_ch.ready);
    tracker.take_request(kind, prio, tag);
    burst_left--;
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  task automatic write_low_level(logic [PRIO_BITS-1:0] lvl);
    drain_responses();
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_low_level(lvl);
  endtask

  task automatic run_directed();
    // remove on empty, then fill with mixed priorities, overflow, partial drain
    send_item(REQ_REMOVE, 2'd3, 16'hFFFF);
    send_item(REQ_INSERT, 2'd0, 16'h0000);
    send_item(REQ_INSERT, 2'd3, 16'hFFFF);
    send_item(REQ_INSERT, 2'd1, 16'h0001);
    send_item(REQ_INSERT, 2'd3, 16'h8000);
    send_item(REQ_INSERT, 2'd2, 16'h7FFF);
    for (int i = 5; i < QUEUE_DEPTH; i++)
      send_item(REQ_INSERT, PRIO_BITS'(i), TAG_BITS'(16'hA5A5 ^ i));
    send_item(REQ_INSERT, 2'd3, 16'h5A5A);
    send_item(REQ_INSERT, 2'd0, 16'hFFFF);
    send_item(REQ_REMOVE, 2'd0, 16'h0000);
    send_item(REQ_REMOVE, 2'd1, 16'h1234);
    send_item(REQ_REMOVE, 2'd2, 16'hEDCB);
    send_item(REQ_INSERT, 2'd0, 16'hC0DE);
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned          insert_pct;
    logic                 kind;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
    insert_pct = 50;
    for (int unsigned k = 0; k < n_items; k++) begin
      // new random insert share every 40 items: fill-heavy and drain-heavy stretches reach both ends
      if (k % 40 == 0) insert_pct = $urandom_range(15, 85);
      if ($urandom_range(0, 149) == 0) drain_responses();
      kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      if ($urandom_range(0, 3) == 0) prio = tracker.low_level;
      else prio = PRIO_BITS'($urandom);
      case ($urandom_range(0, 9))
        0:       tag = '0;
        1:       tag = '1;
        default: tag = TAG_BITS'($urandom);
      endcase
      send_item(kind, prio, tag);
    end
  endtask

  initial begin
    logic [PRIO_BITS-1:0] lvl;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_INSERT;
    req_ch.entry_priority <= '0;
    req_ch.entry_tag      <= '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       lvl = '1;
        1:       lvl = 2'd1;
        2:       lvl = 2'd2;
        3:       lvl = '0;
        default: lvl = PRIO_BITS'($urandom);
      endcase
      write_low_level(lvl);
      run_random(156);
    end

    drain_responses();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
